### rtl/shq_pkg.sv
// ----------------------------------------------------------------------------
// shq_pkg: shared buffer multi-queue package
// Sizes, pointer and payload types, status and action codes.
// ----------------------------------------------------------------------------
package shq_pkg;

    localparam int SLOTS     = 16;
    localparam int QUEUES    = 4;
    localparam int DATA_BITS = 32;

    localparam int QNUM_W = 8;   // queue_number field
    localparam int WORD_W = 32;  // data_in / data_out fields
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PTR_W  = IDX_W + 1;  // msb marks null
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [QNUM_W:0] QUEUE_LIMIT = (QNUM_W + 1)'(QUEUES);
    localparam logic [PTR_W-1:0] SLOT_LIMIT = PTR_W'(SLOTS);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [PTR_W-1:0]     ptr_t;   // {null, index}
    typedef logic [DATA_BITS-1:0] data_t;

    typedef enum logic
    {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADQ  = 2'd3
    } status_t;

    typedef struct packed
    {
        action_t           action;
        logic [QNUM_W-1:0] queue_number;
        logic [WORD_W-1:0] data_in;
    } item_t;

    typedef struct packed
    {
        status_t           status;
        logic [WORD_W-1:0] data_out;
    } res_t;

    typedef struct packed
    {
        logic we;
        idx_t addr;
        ptr_t wdata;
    } link_wr_t;

    typedef struct packed
    {
        logic  we;
        idx_t  addr;
        data_t wdata;
    } data_wr_t;

endpackage

### rtl/shq_ram.sv
// ----------------------------------------------------------------------------
// shq_ram: simple dual-port RAM
// One write port, one registered read port with write-first bypass.
// ----------------------------------------------------------------------------
module shq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            // same-edge write wins
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/shq_ctrl.sv
// ----------------------------------------------------------------------------
// shq_ctrl: queue and free list pointer control
// Head/tail pointers, free list head and fresh-slot count; one item a cycle while commit is high.
// ----------------------------------------------------------------------------
module shq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             commit,
    input  shq_pkg::item_t   cur,
    input  shq_pkg::item_t   nxt,
    input  shq_pkg::ptr_t    link_rd,
    input  shq_pkg::data_t   data_rd,
    output shq_pkg::idx_t    rd_addr,
    output shq_pkg::link_wr_t link_wr,
    output shq_pkg::data_wr_t data_wr,
    output shq_pkg::res_t    res
);
    import shq_pkg::*;

    logic qempty_reg [QUEUES];
    logic qempty_next [QUEUES];
    idx_t qhead_reg [QUEUES];
    idx_t qhead_next [QUEUES];
    idx_t qtail_reg [QUEUES];
    idx_t qtail_next [QUEUES];
    logic free_empty_reg, free_empty_next;
    idx_t free_head_reg, free_head_next;
    ptr_t fresh_reg, fresh_next;   // slots at or above this were never used

    logic [QIDX_W-1:0] qsel;
    logic [QIDX_W-1:0] nsel;
    logic              bad_q;
    idx_t              slot;
    ptr_t              fresh_inc;

    assign qsel      = cur.queue_number[QIDX_W-1:0];
    assign nsel      = nxt.queue_number[QIDX_W-1:0];
    assign bad_q     = {1'b0, cur.queue_number} >= QUEUE_LIMIT;
    assign fresh_inc = fresh_reg + PTR_W'(1);

    always_comb
    begin
        qempty_next     = qempty_reg;
        qhead_next      = qhead_reg;
        qtail_next      = qtail_reg;
        free_empty_next = free_empty_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        slot            = free_head_reg;
        res.status      = ST_OK;
        res.data_out    = '0;
        link_wr.we      = 1'b0;
        link_wr.addr    = qtail_reg[qsel];
        link_wr.wdata   = '0;
        data_wr.we      = 1'b0;
        data_wr.addr    = free_head_reg;
        data_wr.wdata   = data_t'(cur.data_in);

        if (bad_q)
        begin
            res.status = ST_BADQ;
        end
        else if (cur.action == ACT_ENQ)
        begin
            if (free_empty_reg)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                slot = free_head_reg;
                // pop the free list; untouched slots chain in index order
                if ({1'b0, slot} == fresh_reg)
                begin
                    fresh_next = fresh_inc;
                    if (fresh_inc == SLOT_LIMIT)
                    begin
                        free_empty_next = 1'b1;
                    end
                    else
                    begin
                        free_head_next = fresh_inc[IDX_W-1:0];
                    end
                end
                else
                begin
                    free_empty_next = link_rd[IDX_W];
                    free_head_next  = link_rd[IDX_W-1:0];
                end
                if (qempty_reg[qsel])
                begin
                    qempty_next[qsel] = 1'b0;
                    qhead_next[qsel]  = slot;
                end
                else
                begin
                    link_wr.we    = 1'b1;
                    link_wr.addr  = qtail_reg[qsel];
                    link_wr.wdata = {1'b0, slot};
                end
                qtail_next[qsel] = slot;
                data_wr.we       = 1'b1;
                data_wr.addr     = slot;
            end
        end
        else
        begin
            if (qempty_reg[qsel])
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                slot = qhead_reg[qsel];
                // the tail's link is never read, so it needs no null write
                if (slot == qtail_reg[qsel])
                begin
                    qempty_next[qsel] = 1'b1;
                end
                else
                begin
                    qhead_next[qsel] = link_rd[IDX_W-1:0];
                end
                link_wr.we      = 1'b1;
                link_wr.addr    = slot;
                link_wr.wdata   = {free_empty_reg, free_head_reg};
                free_head_next  = slot;
                free_empty_next = 1'b0;
                res.data_out    = WORD_W'(signed'(data_rd));
            end
        end

        if (!commit)
        begin
            qempty_next     = qempty_reg;
            qhead_next      = qhead_reg;
            qtail_next      = qtail_reg;
            free_empty_next = free_empty_reg;
            free_head_next  = free_head_reg;
            fresh_next      = fresh_reg;
            link_wr.we      = 1'b0;
            data_wr.we      = 1'b0;
        end
    end

    // read for the incoming item sees the state this edge leaves behind
    assign rd_addr = (nxt.action == ACT_DEQ) ? qhead_next[nsel] : free_head_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                qempty_reg[i] <= 1'b1;
                qhead_reg[i]  <= '0;
                qtail_reg[i]  <= '0;
            end
            free_empty_reg <= 1'b0;
            free_head_reg  <= '0;
            fresh_reg      <= '0;
        end
        else
        begin
            qempty_reg     <= qempty_next;
            qhead_reg      <= qhead_next;
            qtail_reg      <= qtail_next;
            free_empty_reg <= free_empty_next;
            free_head_reg  <= free_head_next;
            fresh_reg      <= fresh_next;
        end
    end

endmodule

### rtl/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue: several FIFO queues in one shared slot store
// Linked-list queues with a free list; one status result per transfer.
// ----------------------------------------------------------------------------
// usage
// - s_axis carries commands: tuser selects enqueue (0) or dequeue (1),
//   tdata holds the queue number and the value to enqueue
// - m_axis returns one result per command: tuser is the status
//   (ok, store full, queue empty, bad queue number), tdata the dequeued value,
//   zero for enqueues and failed commands
// - a command's transfer loads the command register, where slot and link
//   memories are read and pointers updated; as the command completes, the
//   result register is loaded and the result is offered
// - throughput: one command per cycle unless m_axis stalls; the slot memories take their read
//   address at command transfer and are written as the command completes
// - a stalled m_axis holds the result register; one more command still
//   enters the command register, after that s_axis_tready drops
// - reset: every queue empty, all slots free, nothing pending; no memory
//   clearing pass, slots never used are handed out by a fill count
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // queue_number[7:0], data_in[39:8]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_out[31:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import shq_pkg::*;

    // command register
    logic  s1_valid_reg;
    item_t s1_item_reg;
    // result register
    logic  out_valid_reg;
    res_t  out_res_reg;

    item_t    in_item;
    logic     accept;
    logic     commit;
    idx_t     rd_addr;
    ptr_t     link_rd;
    data_t    data_rd;
    link_wr_t link_wr;
    data_wr_t data_wr;
    res_t     res;

    assign in_item.action       = action_t'(s_axis_tuser);
    assign in_item.queue_number = s_axis_tdata[QNUM_W-1:0];
    assign in_item.data_in      = s_axis_tdata[QNUM_W+WORD_W-1:QNUM_W];

    // the command completes when the result register can take it
    assign commit        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || commit;
    assign accept        = s_axis_tvalid && s_axis_tready;

    shq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .commit  (commit),
        .cur     (s1_item_reg),
        .nxt     (in_item),
        .link_rd (link_rd),
        .data_rd (data_rd),
        .rd_addr (rd_addr),
        .link_wr (link_wr),
        .data_wr (data_wr),
        .res     (res)
    );

    // next-slot links of queues and free list
    shq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (PTR_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_wr.we),
        .waddr (link_wr.addr),
        .wdata (link_wr.wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    // slot payloads
    shq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (DATA_BITS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_wr.we),
        .waddr (data_wr.addr),
        .wdata (data_wr.wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (data_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (commit)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.data_out;
    assign m_axis_tuser  = out_res_reg.status;

endmodule

### rtl/shq_checker.sv
// ----------------------------------------------------------------------------
// shq_checker: port checks for shared_buffer_multi_queue
// Output hold under stall, zero data on failed results, ready when drained.
// ----------------------------------------------------------------------------
module shq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import shq_pkg::*;

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    // failed commands return zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("nonzero data on failed result");

    // with the result register empty the command side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("command side stalled with empty result register");

    // a transfer in always yields a result when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 m_axis_tready
            |=> m_axis_tvalid)
    else $error("result missing after command transfer");

endmodule

bind shared_buffer_multi_queue shq_checker u_shq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/shared_buffer_multi_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_test: self-checking bench for the multi-queue
// Commands are driven on s_axis with random gaps. Each result on m_axis is
// compared with a local queue model, and m_axis_tready is throttled at random.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_test;

    import shq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PERCENT  = 36;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;     // margin after the last expected result
    localparam int HOLD_CYCLES   = 150;   // long m_axis stall
    localparam int RANDOM_ITEMS  = 1200;
    localparam int QUIET_ITEMS   = 300;   // opening stretch with no idling
    localparam int PHASE_ITEMS   = 40;    // length of a fill or drain phase
    localparam int MAX_REPORTS   = 10;

    // clock, reset and dut ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;   // queue_number[7:0], data_in[39:8]
    logic              s_axis_tuser = 1'b0; // action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // data_out[31:0]
    logic [1:0]        m_axis_tuser;        // status[1:0]

    // local model of the queues: contents in fifo order and total slots used
    data_t             queue_contents [QUEUES][$];
    int                slots_used = 0;

    // results predicted for accepted commands, oldest first
    res_t              expected_results [$];

    // run control shared by the sender, the receiver and the checker
    bit                idle_on = 1'b0;
    int                hold_requests = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                cycle_count = 0;
    int                fail_count = 0;
    int                mismatch_count = 0;

    shared_buffer_multi_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of one command: updates the local queues, returns its result
    // ------------------------------------------------------------------------
    function automatic res_t queue_op_result(input action_t act,
                                             input logic [QNUM_W-1:0] qn,
                                             input logic [WORD_W-1:0] din);
        res_t  res;
        data_t word;
        res.status   = ST_OK;
        res.data_out = '0;
        // queue number is checked before anything else, for both actions
        if (qn >= QUEUES)
            res.status = ST_BADQ;
        else if (act == ACT_ENQ)
        begin
            if (slots_used >= SLOTS)
                res.status = ST_FULL;
            else
            begin
                queue_contents[qn].push_back(data_t'(din));
                slots_used++;
            end
        end
        else
        begin
            if (queue_contents[qn].size() == 0)
                res.status = ST_EMPTY;
            else
            begin
                word = queue_contents[qn].pop_front();
                slots_used--;
                // stored word comes back sign-extended to the field width
                res.data_out = WORD_W'(signed'(word));
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // send one command; returns at the edge where its transfer happens
    // ------------------------------------------------------------------------
    task automatic send_command(input action_t act,
                                input logic [QNUM_W-1:0] qn,
                                input logic [WORD_W-1:0] din);
        // random gap before the command
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {din, qn};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(queue_op_result(act, qn, din));
    endtask

    // random command: mostly valid queues, some arbitrary queue numbers
    task automatic send_random_command(input int enq_percent);
        action_t             act;
        logic [QNUM_W-1:0]   qn;
        act = ($urandom_range(0, 99) < enq_percent) ? ACT_ENQ : ACT_DEQ;
        if ($urandom_range(0, 9) == 0)
            qn = QNUM_W'($urandom_range(0, 255));
        else
            qn = QNUM_W'($urandom_range(0, QUEUES - 1));
        send_command(act, qn, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!idle_on)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // checker: every result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d data %h",
                             m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.data_out)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected status %0d data %h, got status %0d data %h",
                                 want.status, want.data_out, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty queues, bad queue numbers, data extremes and fifo order
    task automatic test_empty_and_bad_queue();
        send_command(ACT_DEQ, 8'd0,   32'h0000_0000);  // empty queue
        send_command(ACT_ENQ, 8'd4,   32'h1234_5678);  // first bad number
        send_command(ACT_DEQ, 8'd255, 32'hFFFF_FFFF);  // top bad number
        send_command(ACT_ENQ, 8'd255, 32'hFFFF_FFFF);
        send_command(ACT_ENQ, 8'd0,   32'h8000_0000);
        send_command(ACT_ENQ, 8'd3,   32'h7FFF_FFFF);
        send_command(ACT_ENQ, 8'd0,   32'hFFFF_FFFF);
        send_command(ACT_DEQ, 8'd0,   32'h0000_0000);
        send_command(ACT_DEQ, 8'd0,   32'hFFFF_FFFF);
        send_command(ACT_DEQ, 8'd0,   32'h0000_0000);  // empty again
        send_command(ACT_DEQ, 8'd3,   32'h0000_0000);
    endtask

    // fill every slot, then full store, then bad number while full
    task automatic test_store_full();
        for (int i = 0; i < SLOTS; i++)
            send_command(ACT_ENQ, QNUM_W'(i % QUEUES), $urandom);
        send_command(ACT_ENQ, 8'd2,   32'hDEAD_BEEF);  // store full
        send_command(ACT_ENQ, 8'd200, 32'h0000_0001);  // bad number wins
        send_command(ACT_DEQ, 8'd1,   32'h0000_0000);
        send_command(ACT_ENQ, 8'd1,   32'h5555_AAAA);
    endtask

    // receiver holds off while commands keep coming, input must stall
    task automatic test_output_stall();
        idle_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 24; i++)
            send_random_command(50);
        idle_on = 1'b1;
    endtask

    // random traffic in alternating fill and drain phases
    task automatic test_random_traffic();
        int enq_percent;
        idle_on = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == QUIET_ITEMS)
                idle_on = 1'b1;
            // fill phases push toward a full store, drain phases toward empty
            enq_percent = ((i / PHASE_ITEMS) % 2 == 0) ? 75 : 25;
            send_random_command(enq_percent);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        test_empty_and_bad_queue();
        test_store_full();
        test_output_stall();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/shq_pkg.sv
rtl/shq_ram.sv
rtl/shq_ctrl.sv
rtl/shared_buffer_multi_queue.sv
rtl/shq_checker.sv
tb/shared_buffer_multi_queue_test.sv
